[sv/fdbb_pkg.sv]
// Shared types and constants of the frame difference bounding box block.
// Used by fdbb_tracker and frame_diff_bounding_box; depends on nothing.
package fdbb_pkg;

    // Defaults for the module parameters.
    localparam int DEF_MAX_DIM         = 4096;
    localparam int DEF_MAX_PIXEL_BYTES = 4;

    // Bytes held in one pixel word on the stream.
    localparam int PIXEL_BYTES = 4;

    // Fixed field widths.
    localparam int PIXEL_W  = 32;
    localparam int ORIGIN_W = 12;
    localparam int DIM_W    = 13;
    localparam int BPP_W    = 3;
    localparam int REGION_W = 13;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 3'd4;

    // Register values after reset.
    localparam logic [ORIGIN_W-1:0] RST_WINDOW_X        = 12'd0;
    localparam logic [ORIGIN_W-1:0] RST_WINDOW_Y        = 12'd0;
    localparam logic [DIM_W-1:0]    RST_WINDOW_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]    RST_WINDOW_HEIGHT   = 13'd480;
    localparam logic [BPP_W-1:0]    RST_BYTES_PER_PIXEL = 3'd3;

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // One result of a frame.
    typedef struct packed {
        logic [REGION_W-1:0] region_height;
        logic [REGION_W-1:0] region_width;
        logic [REGION_W-1:0] region_y;
        logic [REGION_W-1:0] region_x;
        logic                changed;
    } region_t;

endpackage

[sv/fdbb_tracker.sv]
// Window position counters and extent tracking of changed pixels.
// Depends on fdbb_pkg for region_t and the field widths.
module fdbb_tracker
    import fdbb_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          diff,
    input  logic [$clog2(MAX_DIM)-1:0]    w_last,
    input  logic [$clog2(MAX_DIM)-1:0]    h_last,
    input  logic [ORIGIN_W-1:0]           window_x,
    input  logic [ORIGIN_W-1:0]           window_y,
    output logic                          frame_end,
    output region_t                       region
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int SW = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [CW-1:0] row_count_reg,    row_count_next;
    logic [CW-1:0] left_most_reg,    left_most_next;
    logic [CW-1:0] right_most_reg,   right_most_next;
    logic [CW-1:0] top_most_reg,     top_most_next;
    logic [CW-1:0] bottom_most_reg,  bottom_most_next;
    logic          any_found_reg,    any_found_next;

    logic [CW-1:0] left_upd, right_upd, top_upd, bottom_upd;
    logic          any_upd;
    logic          row_end;

    // Extents including the current pixel.
    always_comb
    begin
        left_upd   = left_most_reg;
        right_upd  = right_most_reg;
        top_upd    = top_most_reg;
        bottom_upd = bottom_most_reg;
        any_upd    = any_found_reg;
        if (diff)
        begin
            if (!any_found_reg)
            begin
                left_upd  = column_count_reg;
                right_upd = column_count_reg;
                top_upd   = row_count_reg;
                any_upd   = 1'b1;
            end
            else
            begin
                if (column_count_reg < left_most_reg)
                begin
                    left_upd = column_count_reg;
                end
                if (column_count_reg > right_most_reg)
                begin
                    right_upd = column_count_reg;
                end
            end
            bottom_upd = row_count_reg;
        end
    end

    assign row_end   = (column_count_reg >= w_last);
    assign frame_end = row_end && (row_count_reg >= h_last);

    // Rectangle in frame coordinates, all zero when nothing changed.
    always_comb
    begin
        region = '0;
        if (any_upd)
        begin
            region.changed       = 1'b1;
            region.region_x      = REGION_W'(SW'(window_x) + SW'(left_upd));
            region.region_y      = REGION_W'(SW'(window_y) + SW'(top_upd));
            region.region_width  = REGION_W'(SW'(right_upd) - SW'(left_upd) + SW'(1));
            region.region_height = REGION_W'(SW'(bottom_upd) - SW'(top_upd) + SW'(1));
        end
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        left_most_next    = left_most_reg;
        right_most_next   = right_most_reg;
        top_most_next     = top_most_reg;
        bottom_most_next  = bottom_most_reg;
        any_found_next    = any_found_reg;
        if (step)
        begin
            if (frame_end)
            begin
                // Clear for the next frame.
                column_count_next = '0;
                row_count_next    = '0;
                left_most_next    = '0;
                right_most_next   = '0;
                top_most_next     = '0;
                bottom_most_next  = '0;
                any_found_next    = 1'b0;
            end
            else
            begin
                left_most_next   = left_upd;
                right_most_next  = right_upd;
                top_most_next    = top_upd;
                bottom_most_next = bottom_upd;
                any_found_next   = any_upd;
                if (row_end)
                begin
                    column_count_next = '0;
                    row_count_next    = row_count_reg + CW'(1);
                end
                else
                begin
                    column_count_next = column_count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            left_most_reg    <= '0;
            right_most_reg   <= '0;
            top_most_reg     <= '0;
            bottom_most_reg  <= '0;
            any_found_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            left_most_reg    <= left_most_next;
            right_most_reg   <= right_most_next;
            top_most_reg     <= top_most_next;
            bottom_most_reg  <= bottom_most_next;
            any_found_reg    <= any_found_next;
        end
    end

endmodule

[sv/frame_diff_bounding_box.sv]
// The last pixel of a window goes through the input register, then the result register,
// whose valid flag drives m_tvalid.
// Throughput: one pixel pair per cycle;
// the input side stalls only while a finished result waits in the result register and
// the last pixel of the next window would need it. Reset (rst_n, async, active low)
// clears counters, tracking and handshake state and loads the register defaults.
// Top level of the frame difference bounding box; depends on fdbb_pkg and fdbb_tracker.
module frame_diff_bounding_box
    import fdbb_pkg::*;
#(
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Pixel pair stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // new_pixel[31:0], old_pixel[63:32]

    // Result stream, one transfer per window.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // changed[0], region_x[13:1], region_y[26:14],
                                              // region_width[39:27], region_height[52:40],
                                              // zero [55:53]

    // Register writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_DIM);

    // Configuration registers.
    logic [ORIGIN_W-1:0] window_x_reg;
    logic [ORIGIN_W-1:0] window_y_reg;
    logic [DIM_W-1:0]    window_width_reg;
    logic [DIM_W-1:0]    window_height_reg;
    logic [BPP_W-1:0]    bytes_per_pixel_reg;

    // Input stage.
    logic               in_valid_reg, in_valid_next;
    logic [PIXEL_W-1:0] in_new_reg;
    logic [PIXEL_W-1:0] in_old_reg;

    // Result stage.
    logic               out_valid_reg, out_valid_next;
    region_t            out_region_reg;

    logic               s_xfer;
    logic               consume;
    logic               load;
    logic               out_free;
    logic               diff;
    logic [CW-1:0]      w_last;
    logic [CW-1:0]      h_last;
    logic               frame_end;
    region_t            region;
    logic [PIXEL_BYTES-1:0] byte_diff;

    // Writes are always taken; the user must write only while idle, not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_x_reg        <= RST_WINDOW_X;
            window_y_reg        <= RST_WINDOW_Y;
            window_width_reg    <= RST_WINDOW_WIDTH;
            window_height_reg   <= RST_WINDOW_HEIGHT;
            bytes_per_pixel_reg <= RST_BYTES_PER_PIXEL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_X:        window_x_reg        <= cfg_data[ORIGIN_W-1:0];
                REG_WINDOW_Y:        window_y_reg        <= cfg_data[ORIGIN_W-1:0];
                REG_WINDOW_WIDTH:    window_width_reg    <= cfg_data[DIM_W-1:0];
                REG_WINDOW_HEIGHT:   window_height_reg   <= cfg_data[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[BPP_W-1:0];
                default:             ;   // drop writes to unknown indexes
            endcase
        end
    end

    // Last column and row of the window: zero counts as one, large values saturate.
    always_comb
    begin
        if (window_width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(window_width_reg) > MAX_DIM)
        begin
            w_last = CW'(MAX_DIM - 1);
        end
        else
        begin
            w_last = CW'(window_width_reg - DIM_W'(1));
        end

        if (window_height_reg == '0)
        begin
            h_last = '0;
        end
        else if (32'(window_height_reg) > MAX_DIM)
        begin
            h_last = CW'(MAX_DIM - 1);
        end
        else
        begin
            h_last = CW'(window_height_reg - DIM_W'(1));
        end
    end

    // Compare byte i only if it lies below both the configured byte count and
    // the parameter limit; the word itself caps the count at four.
    always_comb
    begin
        for (int i = 0; i < PIXEL_BYTES; i++)
        begin
            byte_diff[i] = (in_new_reg[8*i +: 8] != in_old_reg[8*i +: 8])
                         && (32'(bytes_per_pixel_reg) > i)
                         && (MAX_PIXEL_BYTES > i);
        end
    end

    assign diff = |byte_diff;

    // The held pixel moves on unless it closes a window while the result
    // register is still occupied and m_tready is low.
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!frame_end || out_free);
    assign load     = consume && frame_end;
    assign s_tready = !in_valid_reg || consume;
    assign s_xfer   = s_tvalid && s_tready;

    fdbb_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .diff      (diff),
        .w_last    (w_last),
        .h_last    (h_last),
        .window_x  (window_x_reg),
        .window_y  (window_y_reg),
        .frame_end (frame_end),
        .region    (region)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_new_reg <= s_tdata[PIXEL_W-1:0];
            in_old_reg <= s_tdata[2*PIXEL_W-1:PIXEL_W];
        end
        if (load)
        begin
            out_region_reg <= region;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_region_reg);

`ifndef ASSERT_OFF
    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while full");

    // A pixel that is not consumed stays in the input register unchanged.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_new_reg)
                                        && $stable(in_old_reg)))
        else $error("held pixel lost or changed");

    // A window without change reports an all-zero rectangle.
    a_unchanged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_region_reg.changed) |-> (out_region_reg == '0))
        else $error("unchanged result carries a nonzero rectangle");
`endif

endmodule

[test/tb.sv]
// Self-checking bench for frame_diff_bounding_box: streams pixel pairs and
// checks every result rectangle. Depends on fdbb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import fdbb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LONG_HOLD    = 200;
    localparam int RANDOM_ITEMS = 1320;
    localparam int REGION_BITS  = $bits(region_t);
    // Highest index that the register port can carry.
    localparam int LAST_INDEX   = (1 << CFG_INDEX_W) - 1;

    // One pixel pair as it travels on s_tdata.
    typedef struct packed {
        logic [PIXEL_W-1:0] old_px;
        logic [PIXEL_W-1:0] new_px;
    } pixel_pair_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Window registers as the block should hold them.
    logic [ORIGIN_W-1:0] win_x   = RST_WINDOW_X;
    logic [ORIGIN_W-1:0] win_y   = RST_WINDOW_Y;
    logic [DIM_W-1:0]    win_w   = RST_WINDOW_WIDTH;
    logic [DIM_W-1:0]    win_h   = RST_WINDOW_HEIGHT;
    logic [BPP_W-1:0]    win_bpp = RST_BYTES_PER_PIXEL;

    // Scan position and bounds of differing pixels in the current window.
    logic [ORIGIN_W-1:0] px_col = '0;
    logic [ORIGIN_W-1:0] px_row = '0;
    logic [ORIGIN_W-1:0] left_col = '0;
    logic [ORIGIN_W-1:0] right_col = '0;
    logic [ORIGIN_W-1:0] top_row = '0;
    logic [ORIGIN_W-1:0] bottom_row = '0;
    logic                diff_seen = 1'b0;

    pixel_pair_t pixel_queue[$];
    region_t     rect_queue[$];

    int pixels_pushed = 0;
    int pixels_accepted = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int holds_asked = 0;
    int holds_served = 0;
    // Idle behavior per side: 0 runs flat out, 1 inserts random gaps.
    int src_mode = 0;
    int sink_mode = 0;

    frame_diff_bounding_box u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Zero counts as one, anything past the maximum saturates.
    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_MAX_DIM)
            return DEF_MAX_DIM;
        return int'(v);
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_X:        win_x = data[ORIGIN_W-1:0];
            REG_WINDOW_Y:        win_y = data[ORIGIN_W-1:0];
            REG_WINDOW_WIDTH:    win_w = data;
            REG_WINDOW_HEIGHT:   win_h = data;
            REG_BYTES_PER_PIXEL: win_bpp = data[BPP_W-1:0];
            default:             ;
        endcase
    endfunction

    // Advance the scan by one accepted pixel pair; queue the rectangle that
    // the last pixel of a window produces.
    function automatic void track_pixel(input logic [PIXEL_W-1:0] new_px,
                                        input logic [PIXEL_W-1:0] old_px);
        logic [PIXEL_W-1:0] mask;
        int                 w;
        int                 h;
        int                 n;
        logic               row_end;
        region_t            rect;
        w = eff_dim(win_w);
        h = eff_dim(win_h);
        n = (win_bpp > DEF_MAX_PIXEL_BYTES) ? DEF_MAX_PIXEL_BYTES : int'(win_bpp);
        mask = (n >= PIXEL_BYTES) ? '1 : ((32'd1 << (8 * n)) - 32'd1);
        if (((new_px ^ old_px) & mask) != 0)
        begin
            if (!diff_seen)
            begin
                left_col = px_col;
                right_col = px_col;
                top_row = px_row;
                diff_seen = 1'b1;
            end
            else
            begin
                if (px_col < left_col)
                    left_col = px_col;
                if (px_col > right_col)
                    right_col = px_col;
            end
            bottom_row = px_row;
        end
        // Use reaches-or-passes so that a mid-window shrink still ends the row.
        row_end = int'(px_col) >= w - 1;
        if (!(row_end && int'(px_row) >= h - 1))
        begin
            if (row_end)
            begin
                px_col = '0;
                px_row = px_row + 1'b1;
            end
            else
                px_col = px_col + 1'b1;
            return;
        end
        rect = '0;
        if (diff_seen)
        begin
            rect.changed = 1'b1;
            rect.region_x = {1'b0, win_x} + {1'b0, left_col};
            rect.region_y = {1'b0, win_y} + {1'b0, top_row};
            rect.region_width = {1'b0, right_col} - {1'b0, left_col} + 13'd1;
            rect.region_height = {1'b0, bottom_row} - {1'b0, top_row} + 13'd1;
        end
        rect_queue.push_back(rect);
        px_col = '0;
        px_row = '0;
        left_col = '0;
        right_col = '0;
        top_row = '0;
        bottom_row = '0;
        diff_seen = 1'b0;
    endfunction

    function automatic void flag_field(input string name, input logic [REGION_W-1:0] want,
                                       input logic [REGION_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_rect(input region_t got);
        region_t want;
        if (rect_queue.size() == 0)
        begin
            fail_count++;
            $display("%0t: result expected none got %h", $time, got);
            return;
        end
        want = rect_queue.pop_front();
        flag_field("changed", REGION_W'(want.changed), REGION_W'(got.changed));
        flag_field("region_x", want.region_x, got.region_x);
        flag_field("region_y", want.region_y, got.region_y);
        flag_field("region_width", want.region_width, got.region_width);
        flag_field("region_height", want.region_height, got.region_height);
    endfunction

    // Mode 0 gives no gap; otherwise mostly no gap, some short ones, a few long ones.
    function automatic int idle_length(input int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Random pixel; with the given chance the old pixel differs in one byte
    // lane or is drawn anew at random.
    function automatic pixel_pair_t make_pair(input int diff_pct);
        pixel_pair_t p;
        p.new_px = $urandom;
        p.old_px = p.new_px;
        if ($urandom_range(99) < diff_pct)
        begin
            if ($urandom_range(1) == 1)
                p.old_px = $urandom;
            else
                p.old_px = p.new_px ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
        end
        return p;
    endfunction

    function automatic void push_pixel(input logic [PIXEL_W-1:0] new_px,
                                       input logic [PIXEL_W-1:0] old_px);
        pixel_pair_t p;
        p.new_px = new_px;
        p.old_px = old_px;
        pixel_queue.push_back(p);
        pixels_pushed++;
    endfunction

    function automatic void push_random(input int count, input int diff_pct);
        pixel_pair_t p;
        for (int i = 0; i < count; i++)
        begin
            p = make_pair(diff_pct);
            push_pixel(p.new_px, p.old_px);
        end
    endfunction

    // Raise the write channel and hold it until the transfer; the caller
    // drops cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic load_window(input logic [CFG_DATA_W-1:0] x, input logic [CFG_DATA_W-1:0] y,
                               input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] bpp);
        write_reg(REG_WINDOW_X, x);
        write_reg(REG_WINDOW_Y, y);
        write_reg(REG_WINDOW_WIDTH, w);
        write_reg(REG_WINDOW_HEIGHT, h);
        write_reg(REG_BYTES_PER_PIXEL, bpp);
        cfg_valid <= 1'b0;
    endtask

    // Pause the sender until every pixel went in and every rectangle came
    // out, then let the last held pixel drain.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (!(pixels_accepted == pixels_pushed && rect_queue.size() == 0));
        repeat (4) @(posedge clk);
    endtask

    // Pixel driver: predict on each transfer, hold an offered pair while
    // stalled, otherwise insert a gap or offer the next queued pair.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_pixel(s_tdata[PIXEL_W-1:0], s_tdata[2*PIXEL_W-1:PIXEL_W]);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    s_tdata <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = idle_length(src_mode);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: check each transfer, then decide whether to stall.
    // A requested long hold-off is counted out here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_rect(region_t'(m_tdata[REGION_BITS-1:0]));
            if (holds_served != holds_asked)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && sink_mode != 0 && $urandom_range(3) == 0)
                stall_left = idle_length(sink_mode);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int          random_items;
        int          frames;
        int          w;
        int          h;
        int          pct;
        int          cut;

        random_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset origin and byte count, small window: a difference in byte 3
        // is ignored, one in byte 2 counts.
        src_mode = 1;
        sink_mode = 1;
        write_reg(REG_WINDOW_WIDTH, 13'd3);
        write_reg(REG_WINDOW_HEIGHT, 13'd2);
        cfg_valid <= 1'b0;
        push_pixel(32'h12345678, 32'hED345678);
        push_pixel(32'h00000000, 32'h00FF0000);
        push_random(4, 0);
        wait_idle();

        // Zero width and height act as one; zero bytes compare nothing;
        // the origin drops its top data bit.
        load_window(13'h1FFF, 13'h1000, 13'd0, 13'd0, 13'd0);
        push_pixel(32'hFFFFFFFF, 32'h00000000);
        wait_idle();
        // Byte count above four compares the whole word.
        write_reg(REG_BYTES_PER_PIXEL, 13'd7);
        cfg_valid <= 1'b0;
        push_pixel(32'h00000000, 32'hFF000000);
        push_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
        push_pixel(32'h00000000, 32'hFFFFFFFF);
        wait_idle();
        // Writes to unused indexes must change nothing.
        for (int i = REG_BYTES_PER_PIXEL + 1; i <= LAST_INDEX; i++)
            write_reg(CFG_INDEX_W'(i), 13'h1FFF);
        cfg_valid <= 1'b0;
        push_pixel(32'h80000000, 32'h00000000);
        wait_idle();

        // Narrow the width in mid-window below the current column.
        load_window(13'd5, 13'd9, 13'd4, 13'd3, 13'd4);
        push_random(6, 50);
        wait_idle();
        write_reg(REG_WINDOW_WIDTH, 13'd2);
        cfg_valid <= 1'b0;
        push_random(3, 50);
        wait_idle();
        // Lower the height in mid-window below the current row.
        load_window(13'd0, 13'd0, 13'd2, 13'd4, 13'd2);
        push_random(6, 50);
        wait_idle();
        write_reg(REG_WINDOW_HEIGHT, 13'd2);
        cfg_valid <= 1'b0;
        push_random(2, 50);
        wait_idle();

        // Saturated width at the far origin: the long first row must not end
        // early; narrow the width in mid-window to close it.
        src_mode = 0;
        sink_mode = 0;
        load_window(13'd4095, 13'd4095, 13'h1FFF, 13'd1, 13'd4);
        push_random(30, 50);
        wait_idle();
        write_reg(REG_WINDOW_WIDTH, 13'd2);
        cfg_valid <= 1'b0;
        push_random(1, 100);
        wait_idle();
        // Saturated height, one column: lower the height to close it.
        load_window(13'd4095, 13'd4095, 13'd1, 13'h1FFF, 13'd1);
        push_random(30, 50);
        wait_idle();
        write_reg(REG_WINDOW_HEIGHT, 13'd2);
        cfg_valid <= 1'b0;
        push_random(1, 100);
        wait_idle();

        // One-pixel windows while the receiver holds off: the block fills
        // and must stall the pixel stream until the receiver resumes.
        src_mode = 1;
        load_window(13'd100, 13'd200, 13'd1, 13'd1, 13'd4);
        holds_asked++;
        push_random(40, 50);
        wait_idle();

        // Random windows, mostly small, with whole windows of random content
        // and now and then a cut-off window left for the next settings.
        while (random_items < RANDOM_ITEMS)
        begin
            src_mode = ($urandom_range(3) == 0) ? 0 : 1;
            sink_mode = ($urandom_range(3) == 0) ? 0 : 1;
            if ($urandom_range(9) < 7)
                write_reg(REG_WINDOW_X, CFG_DATA_W'($urandom_range(8191)));
            if ($urandom_range(9) < 7)
                write_reg(REG_WINDOW_Y, CFG_DATA_W'($urandom_range(8191)));
            if ($urandom_range(9) < 7)
                write_reg(REG_WINDOW_WIDTH,
                          CFG_DATA_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8)));
            if ($urandom_range(9) < 7)
                write_reg(REG_WINDOW_HEIGHT,
                          CFG_DATA_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6)));
            if ($urandom_range(9) < 7)
                write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(7)));
            cfg_valid <= 1'b0;
            w = eff_dim(win_w);
            h = eff_dim(win_h);
            frames = $urandom_range(1, 6);
            for (int f = 0; f < frames; f++)
            begin
                case ($urandom_range(3))
                    0:       pct = 0;
                    1:       pct = 10;
                    2:       pct = 40;
                    default: pct = 100;
                endcase
                push_random(w * h, pct);
                random_items += w * h;
            end
            if (w * h > 1 && $urandom_range(9) == 0)
            begin
                cut = $urandom_range(1, w * h - 1);
                push_random(cut, 30);
                random_items += cut;
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && rect_queue.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
